// ----- hw/rtl/bscf_pkg.sv -----
// Shared types and constants of the bus servo command framer.
package bscf_pkg;

    typedef enum logic [1:0] {
        CMD_MOVE   = 2'd0,
        CMD_HOME   = 2'd1,
        CMD_TORQUE = 2'd2
    } cmd_t;

    localparam logic [2:0] REG_YAW_ID     = 3'd0;
    localparam logic [2:0] REG_PITCH_ID   = 3'd1;
    localparam logic [2:0] REG_YAW_REST   = 3'd2;
    localparam logic [2:0] REG_YAW_MIN    = 3'd3;
    localparam logic [2:0] REG_YAW_MAX    = 3'd4;
    localparam logic [2:0] REG_PITCH_REST = 3'd5;
    localparam logic [2:0] REG_PITCH_MIN  = 3'd6;
    localparam logic [2:0] REG_PITCH_MAX  = 3'd7;

    localparam logic [7:0] RST_YAW_ID     = 8'd1;
    localparam logic [7:0] RST_PITCH_ID   = 8'd2;
    localparam logic [9:0] RST_YAW_REST   = 10'd460;
    localparam logic [9:0] RST_YAW_MIN    = 10'd60;
    localparam logic [9:0] RST_YAW_MAX    = 10'd860;
    localparam logic [9:0] RST_PITCH_REST = 10'd640;
    localparam logic [9:0] RST_PITCH_MIN  = 10'd620;
    localparam logic [9:0] RST_PITCH_MAX  = 10'd900;

    localparam logic [7:0] HDR_BYTE    = 8'hFF;
    localparam logic [7:0] INSTR_WRITE = 8'h03;
    localparam logic [7:0] ADDR_TORQUE = 8'd40;
    localparam logic [7:0] ADDR_GOAL   = 8'd42;
    localparam logic [7:0] LEN_GOAL    = 8'd9;
    localparam logic [7:0] LEN_TORQUE  = 8'd4;
    localparam logic [3:0] GOAL_END    = 4'd12;
    localparam logic [3:0] TORQUE_END  = 4'd7;

    localparam logic [9:0]  SPEED_MAX  = 10'd1000;
    localparam logic [10:0] TIME_BASE  = 11'd1400;
    localparam logic [13:0] RECIP_FIVE = 14'd13108;

    typedef struct packed {
        logic [7:0] yaw_id;
        logic [7:0] tilt_id;
        logic [9:0] yaw_center;
        logic [9:0] yaw_min;
        logic [9:0] yaw_max;
        logic [9:0] tilt_center;
        logic [9:0] tilt_min;
        logic [9:0] tilt_max;
    } cfg_t;

    typedef struct packed {
        logic              torque;
        logic [7:0]        yaw_id;
        logic [7:0]        tilt_id;
        logic [9:0]        yaw_pos;
        logic [9:0]        pitch_pos;
        logic [15:0]       move_time;
        logic              torque_on;
        logic signed [9:0] aim_yaw;
        logic signed [9:0] aim_pitch;
    } job_t;

endpackage

// ----- hw/rtl/bscf_calc.sv -----
// Command pipeline: input register, scaling multipliers, clamp and job build.
module bscf_calc (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          in_cmd,
    input  logic signed [9:0]   in_yaw_deg,
    input  logic signed [9:0]   in_tilt_deg,
    input  logic [9:0]          in_speed,
    input  logic [15:0]         in_home_time,
    input  logic                in_torque_on,
    input  bscf_pkg::cfg_t      cfg,
    output logic                job_valid,
    input  logic                job_ready,
    output bscf_pkg::job_t      job
);

    logic              a_valid_reg;
    logic [1:0]        a_cmd_reg;
    logic signed [9:0] a_yaw_reg;
    logic signed [9:0] a_pitch_reg;
    logic [9:0]        a_speed_reg;
    logic [15:0]       a_time_reg;
    logic              a_ten_reg;

    logic              b_valid_reg;
    logic [1:0]        b_cmd_reg;
    logic signed [9:0] b_yaw_reg;
    logic signed [9:0] b_pitch_reg;
    logic [10:0]       b_yaw_q_reg;
    logic [10:0]       b_pitch_q_reg;
    logic [10:0]       b_tq_reg;
    logic [15:0]       b_time_reg;
    logic              b_ten_reg;

    logic signed [9:0] aim_yaw_reg;
    logic signed [9:0] aim_pitch_reg;

    logic              a_ready;
    logic              b_ready;
    logic              cmd_known;
    logic [9:0]        yaw_mag;
    logic [9:0]        pitch_mag;
    logic [23:0]       yaw_prod;
    logic [23:0]       pitch_prod;
    logic [9:0]        speed_sat;
    logic [12:0]       speed_x6;
    logic [26:0]       time_prod;
    logic              is_move;
    logic              is_home;

    function automatic logic [9:0] clamp_pos(
        input logic [9:0]  rest,
        input logic [10:0] q,
        input logic        neg,
        input logic [9:0]  lo,
        input logic [9:0]  hi
    );
        logic signed [12:0] raw;
        logic [9:0]         res;
        raw = neg ? ($signed({3'b000, rest}) - $signed({2'b00, q}))
                  : ($signed({3'b000, rest}) + $signed({2'b00, q}));
        if (raw < $signed({3'b000, lo})) begin
            res = lo;
        end else if (raw > $signed({3'b000, hi})) begin
            res = hi;
        end else begin
            res = raw[9:0];
        end
        return res;
    endfunction

    assign b_ready   = !b_valid_reg || job_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign in_ready  = a_ready;
    assign job_valid = b_valid_reg;

    assign cmd_known = (in_cmd == bscf_pkg::CMD_MOVE) || (in_cmd == bscf_pkg::CMD_HOME)
                    || (in_cmd == bscf_pkg::CMD_TORQUE);

    assign yaw_mag    = a_yaw_reg[9] ? 10'(-a_yaw_reg) : 10'(a_yaw_reg);
    assign pitch_mag  = a_pitch_reg[9] ? 10'(-a_pitch_reg) : 10'(a_pitch_reg);
    assign yaw_prod   = 24'(yaw_mag) * 24'(bscf_pkg::RECIP_FIVE);
    assign pitch_prod = 24'(pitch_mag) * 24'(bscf_pkg::RECIP_FIVE);
    assign speed_sat  = (a_speed_reg > bscf_pkg::SPEED_MAX) ? bscf_pkg::SPEED_MAX : a_speed_reg;
    assign speed_x6   = {1'b0, speed_sat, 2'b00} + {2'b00, speed_sat, 1'b0};
    assign time_prod  = 27'(speed_x6) * 27'(bscf_pkg::RECIP_FIVE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= in_valid && cmd_known;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready) begin
            a_cmd_reg   <= in_cmd;
            a_yaw_reg   <= in_yaw_deg;
            a_pitch_reg <= in_tilt_deg;
            a_speed_reg <= in_speed;
            a_time_reg  <= in_home_time;
            a_ten_reg   <= in_torque_on;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_valid_reg && b_ready) begin
            b_cmd_reg     <= a_cmd_reg;
            b_yaw_reg     <= a_yaw_reg;
            b_pitch_reg   <= a_pitch_reg;
            b_yaw_q_reg   <= yaw_prod[22:12];
            b_pitch_q_reg <= pitch_prod[22:12];
            b_tq_reg      <= time_prod[26:16];
            b_time_reg    <= a_time_reg;
            b_ten_reg     <= a_ten_reg;
        end
    end

    assign is_move = (b_cmd_reg == bscf_pkg::CMD_MOVE);
    assign is_home = (b_cmd_reg == bscf_pkg::CMD_HOME);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            aim_yaw_reg   <= '0;
            aim_pitch_reg <= '0;
        end else if (b_valid_reg && job_ready) begin
            aim_yaw_reg   <= job.aim_yaw;
            aim_pitch_reg <= job.aim_pitch;
        end
    end

    always_comb
    begin
        job.torque    = !is_move && !is_home;
        job.yaw_id    = cfg.yaw_id;
        job.tilt_id   = cfg.tilt_id;
        job.torque_on = b_ten_reg;
        if (is_move) begin
            job.yaw_pos   = clamp_pos(cfg.yaw_center, b_yaw_q_reg, b_yaw_reg[9],
                                      cfg.yaw_min, cfg.yaw_max);
            job.pitch_pos = clamp_pos(cfg.tilt_center, b_pitch_q_reg, b_pitch_reg[9],
                                      cfg.tilt_min, cfg.tilt_max);
            job.move_time = {5'b00000, bscf_pkg::TIME_BASE - b_tq_reg};
            job.aim_yaw   = b_yaw_reg;
            job.aim_pitch = b_pitch_reg;
        end else if (is_home) begin
            job.yaw_pos   = cfg.yaw_center;
            job.pitch_pos = cfg.tilt_center;
            job.move_time = b_time_reg;
            job.aim_yaw   = '0;
            job.aim_pitch = '0;
        end else begin
            job.yaw_pos   = cfg.yaw_center;
            job.pitch_pos = cfg.tilt_center;
            job.move_time = b_time_reg;
            job.aim_yaw   = aim_yaw_reg;
            job.aim_pitch = aim_pitch_reg;
        end
    end

endmodule

// ----- hw/rtl/bscf_serial.sv -----
// Frame byte sequencer with running checksum and output register.
module bscf_serial (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_ready,
    input  bscf_pkg::job_t      job,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                out_frame_end,
    output logic                out_last,
    output logic signed [9:0]   out_aim_yaw,
    output logic signed [9:0]   out_aim_pitch
);

    logic              busy_reg;
    bscf_pkg::job_t    job_reg;
    logic              second_reg;
    logic [3:0]        idx_reg;
    logic [7:0]        sum_reg;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_end_reg;
    logic              out_last_reg;
    logic signed [9:0] out_aim_yaw_reg;
    logic signed [9:0] out_aim_pitch_reg;

    logic              step;
    logic              at_end;
    logic              final_byte;
    logic [7:0]        cur_id;
    logic [9:0]        cur_pos;
    logic [7:0]        cur_byte;

    assign step       = busy_reg && (!out_valid_reg || out_ready);
    assign at_end     = idx_reg == (job_reg.torque ? bscf_pkg::TORQUE_END : bscf_pkg::GOAL_END);
    assign final_byte = at_end && second_reg;
    assign job_ready  = !busy_reg || (step && final_byte);
    assign cur_id     = second_reg ? job_reg.tilt_id : job_reg.yaw_id;
    assign cur_pos    = second_reg ? job_reg.pitch_pos : job_reg.yaw_pos;

    always_comb
    begin
        unique case (idx_reg)
            4'd0, 4'd1: cur_byte = bscf_pkg::HDR_BYTE;
            4'd2:       cur_byte = cur_id;
            4'd3:       cur_byte = job_reg.torque ? bscf_pkg::LEN_TORQUE : bscf_pkg::LEN_GOAL;
            4'd4:       cur_byte = bscf_pkg::INSTR_WRITE;
            4'd5:       cur_byte = job_reg.torque ? bscf_pkg::ADDR_TORQUE : bscf_pkg::ADDR_GOAL;
            4'd6:       cur_byte = job_reg.torque ? {7'b0000000, job_reg.torque_on}
                                                  : {6'b000000, cur_pos[9:8]};
            4'd7:       cur_byte = job_reg.torque ? ~sum_reg : cur_pos[7:0];
            4'd8:       cur_byte = job_reg.move_time[15:8];
            4'd9:       cur_byte = job_reg.move_time[7:0];
            4'd12:      cur_byte = ~sum_reg;
            default:    cur_byte = 8'h00;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg   <= 1'b0;
            second_reg <= 1'b0;
            idx_reg    <= '0;
        end else if (job_valid && job_ready) begin
            busy_reg   <= 1'b1;
            second_reg <= 1'b0;
            idx_reg    <= '0;
        end else if (step && final_byte) begin
            busy_reg <= 1'b0;
        end else if (step) begin
            if (at_end) begin
                idx_reg    <= '0;
                second_reg <= 1'b1;
            end else begin
                idx_reg <= idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && job_ready) begin
            job_reg <= job;
        end
        if (step) begin
            sum_reg <= (idx_reg < 4'd2) ? 8'h00 : sum_reg + cur_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step) begin
            out_byte_reg      <= cur_byte;
            out_end_reg       <= at_end;
            out_last_reg      <= final_byte;
            out_aim_yaw_reg   <= job_reg.aim_yaw;
            out_aim_pitch_reg <= job_reg.aim_pitch;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign out_frame_end = out_end_reg;
    assign out_last      = out_last_reg;
    assign out_aim_yaw   = out_aim_yaw_reg;
    assign out_aim_pitch = out_aim_pitch_reg;

endmodule

// ----- hw/rtl/bus_servo_command_framer_core.sv -----
// Top level of the bus servo command framer: stream ports, configuration registers.
// The first byte of a command passes the input, scaling, job and output registers.
// A move or home command produces 26 bytes and a torque command 16, one byte per cycle
// from the frame sequencer while the output is not stalled.
// A new command is taken while the previous one is still being sent.
// Reset clears all control state and the kept aim, and loads the register defaults.
module bus_servo_command_framer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // yaw_deg, tilt_deg, speed, home_time_ms, torque_on
    input  logic [1:0]  s_axis_tuser,  // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // tx_byte, aim_yaw, aim_pitch
    output logic        m_axis_tuser,  // frame_end
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [9:0]  cfg_data
);

    bscf_pkg::cfg_t    cfg_reg;
    bscf_pkg::job_t    job;
    logic              job_valid;
    logic              job_ready;
    logic [7:0]        tx_byte;
    logic signed [9:0] aim_yaw;
    logic signed [9:0] aim_pitch;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.yaw_id      <= bscf_pkg::RST_YAW_ID;
            cfg_reg.tilt_id     <= bscf_pkg::RST_PITCH_ID;
            cfg_reg.yaw_center  <= bscf_pkg::RST_YAW_REST;
            cfg_reg.yaw_min     <= bscf_pkg::RST_YAW_MIN;
            cfg_reg.yaw_max     <= bscf_pkg::RST_YAW_MAX;
            cfg_reg.tilt_center <= bscf_pkg::RST_PITCH_REST;
            cfg_reg.tilt_min    <= bscf_pkg::RST_PITCH_MIN;
            cfg_reg.tilt_max    <= bscf_pkg::RST_PITCH_MAX;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                bscf_pkg::REG_YAW_ID:     cfg_reg.yaw_id      <= cfg_data[7:0];
                bscf_pkg::REG_PITCH_ID:   cfg_reg.tilt_id     <= cfg_data[7:0];
                bscf_pkg::REG_YAW_REST:   cfg_reg.yaw_center  <= cfg_data;
                bscf_pkg::REG_YAW_MIN:    cfg_reg.yaw_min     <= cfg_data;
                bscf_pkg::REG_YAW_MAX:    cfg_reg.yaw_max     <= cfg_data;
                bscf_pkg::REG_PITCH_REST: cfg_reg.tilt_center <= cfg_data;
                bscf_pkg::REG_PITCH_MIN:  cfg_reg.tilt_min    <= cfg_data;
                bscf_pkg::REG_PITCH_MAX:  cfg_reg.tilt_max    <= cfg_data;
            endcase
        end
    end

    bscf_calc u_calc (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_cmd       (s_axis_tuser),
        .in_yaw_deg   (s_axis_tdata[9:0]),
        .in_tilt_deg  (s_axis_tdata[19:10]),
        .in_speed     (s_axis_tdata[29:20]),
        .in_home_time (s_axis_tdata[45:30]),
        .in_torque_on (s_axis_tdata[46]),
        .cfg          (cfg_reg),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job          (job)
    );

    bscf_serial u_serial (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (job_valid),
        .job_ready     (job_ready),
        .job           (job),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_byte      (tx_byte),
        .out_frame_end (m_axis_tuser),
        .out_last      (m_axis_tlast),
        .out_aim_yaw   (aim_yaw),
        .out_aim_pitch (aim_pitch)
    );

    assign m_axis_tdata = {4'b0000, aim_pitch, aim_yaw, tx_byte};

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench of the bus servo command framer core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bscf_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [1:0]        cmd;
        logic signed [9:0] yaw_deg;
        logic signed [9:0] tilt_deg;
        logic [9:0]        speed;
        logic [15:0]       home_time;
        logic              torque_on;
    } head_cmd_t;

    typedef struct {
        logic [7:0]        tx_byte;
        logic              frame_end;
        logic              last;
        logic signed [9:0] aim_yaw;
        logic signed [9:0] aim_pitch;
    } bus_byte_t;

    class servo_frame_scoreboard;
        cfg_t              regs;
        logic signed [9:0] aim_yaw;
        logic signed [9:0] aim_pitch;
        bus_byte_t         pending_bytes[$];
        logic [7:0]        cmd_bytes[$];
        logic              cmd_ends[$];
        int                errors;

        function new();
            regs = '{RST_YAW_ID, RST_PITCH_ID, RST_YAW_REST, RST_YAW_MIN, RST_YAW_MAX,
                     RST_PITCH_REST, RST_PITCH_MIN, RST_PITCH_MAX};
            aim_yaw = '0;
            aim_pitch = '0;
            errors = 0;
        endfunction

        function int pending();
            return pending_bytes.size();
        endfunction

        function void write_reg(logic [2:0] idx, logic [9:0] value);
            case (idx)
                REG_YAW_ID:     regs.yaw_id = value[7:0];
                REG_PITCH_ID:   regs.tilt_id = value[7:0];
                REG_YAW_REST:   regs.yaw_center = value;
                REG_YAW_MIN:    regs.yaw_min = value;
                REG_YAW_MAX:    regs.yaw_max = value;
                REG_PITCH_REST: regs.tilt_center = value;
                REG_PITCH_MIN:  regs.tilt_min = value;
                REG_PITCH_MAX:  regs.tilt_max = value;
                default: ;
            endcase
        endfunction

        function void put_byte(logic [7:0] b, logic e);
            cmd_bytes.push_back(b);
            cmd_ends.push_back(e);
        endfunction

        // Data bytes are taken from the top of the data word down.
        function void put_frame(logic [7:0] id, logic [7:0] addr, logic [47:0] data, int n);
            logic [7:0] len;
            logic [7:0] sum;
            logic [7:0] d;
            len = 8'(n + 3);
            sum = id + len + INSTR_WRITE + addr;
            put_byte(HDR_BYTE, 1'b0);
            put_byte(HDR_BYTE, 1'b0);
            put_byte(id, 1'b0);
            put_byte(len, 1'b0);
            put_byte(INSTR_WRITE, 1'b0);
            put_byte(addr, 1'b0);
            for (int i = 0; i < n; i++)
            begin
                d = data[47 - 8 * i -: 8];
                sum = sum + d;
                put_byte(d, 1'b0);
            end
            put_byte(~sum, 1'b1);
        endfunction

        function void put_goal(logic [7:0] id, logic [9:0] pos, logic [15:0] ms);
            put_frame(id, ADDR_GOAL, {6'b0, pos, ms, 16'h0000}, 6);
        endfunction

        function logic [9:0] goal_pos(int deg, logic [9:0] rest, logic [9:0] lo,
                                      logic [9:0] hi);
            int raw;
            raw = int'(rest) + (deg * 32) / 10;
            if (raw < int'(lo))
                return lo;
            if (raw > int'(hi))
                return hi;
            return 10'(raw);
        endfunction

        function void note_command(head_cmd_t c);
            int         spd;
            logic [15:0] ms;
            bus_byte_t  e;
            cmd_bytes.delete();
            cmd_ends.delete();
            if (c.cmd == CMD_MOVE)
            begin
                spd = (c.speed > SPEED_MAX) ? int'(SPEED_MAX) : int'(c.speed);
                ms = 16'(int'(TIME_BASE) - (spd * 1200) / 1000);
                put_goal(regs.yaw_id,
                         goal_pos(c.yaw_deg, regs.yaw_center, regs.yaw_min, regs.yaw_max),
                         ms);
                put_goal(regs.tilt_id,
                         goal_pos(c.tilt_deg, regs.tilt_center, regs.tilt_min,
                                  regs.tilt_max), ms);
                aim_yaw = c.yaw_deg;
                aim_pitch = c.tilt_deg;
            end
            else if (c.cmd == CMD_HOME)
            begin
                put_goal(regs.yaw_id, regs.yaw_center, c.home_time);
                put_goal(regs.tilt_id, regs.tilt_center, c.home_time);
                aim_yaw = '0;
                aim_pitch = '0;
            end
            else if (c.cmd == CMD_TORQUE)
            begin
                put_frame(regs.yaw_id, ADDR_TORQUE, {7'b0, c.torque_on, 40'b0}, 1);
                put_frame(regs.tilt_id, ADDR_TORQUE, {7'b0, c.torque_on, 40'b0}, 1);
            end
            for (int k = 0; k < cmd_bytes.size(); k++)
            begin
                e.tx_byte = cmd_bytes[k];
                e.frame_end = cmd_ends[k];
                e.last = (k == cmd_bytes.size() - 1);
                e.aim_yaw = aim_yaw;
                e.aim_pitch = aim_pitch;
                pending_bytes.push_back(e);
            end
        endfunction

        task report(string msg);
            if (errors < 50)
                $display("%0t ns: mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_byte(bus_byte_t got);
            bus_byte_t want;
            if (pending_bytes.size() == 0)
            begin
                report($sformatf("unexpected byte %02h", got.tx_byte));
                return;
            end
            want = pending_bytes.pop_front();
            if (got.tx_byte !== want.tx_byte)
                report($sformatf("tx_byte %02h, expected %02h", got.tx_byte, want.tx_byte));
            if (got.frame_end !== want.frame_end)
                report($sformatf("frame_end %b, expected %b", got.frame_end, want.frame_end));
            if (got.last !== want.last)
                report($sformatf("last %b, expected %b", got.last, want.last));
            if (got.aim_yaw !== want.aim_yaw)
                report($sformatf("aim_yaw %0d, expected %0d", got.aim_yaw, want.aim_yaw));
            if (got.aim_pitch !== want.aim_pitch)
                report($sformatf("aim_pitch %0d, expected %0d", got.aim_pitch,
                                 want.aim_pitch));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_addr = '0;
    logic [9:0]  cfg_data = '0;

    logic        hold = 1'b0;
    int          idle_pct = 0;
    int          stall_pct = 0;

    servo_frame_scoreboard frames = new();

    bus_servo_command_framer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (hold)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        bus_byte_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.tx_byte = m_axis_tdata[7:0];
            got.aim_yaw = m_axis_tdata[17:8];
            got.aim_pitch = m_axis_tdata[27:18];
            got.frame_end = m_axis_tuser;
            got.last = m_axis_tlast;
            frames.check_byte(got);
        end
    end

    function automatic head_cmd_t make_cmd(logic [1:0] cmd, int yd, int pd, int spd,
                                           int ms, bit ten);
        head_cmd_t c;
        c.cmd = cmd;
        c.yaw_deg = 10'(yd);
        c.tilt_deg = 10'(pd);
        c.speed = 10'(spd);
        c.home_time = 16'(ms);
        c.torque_on = ten;
        return c;
    endfunction

    function automatic head_cmd_t random_cmd();
        head_cmd_t c;
        int        r;
        r = $urandom_range(99);
        if (r < 45)
            c.cmd = CMD_MOVE;
        else if (r < 65)
            c.cmd = CMD_HOME;
        else if (r < 94)
            c.cmd = CMD_TORQUE;
        else
            c.cmd = CMD_UNUSED;
        if ($urandom_range(1) == 0)
        begin
            c.yaw_deg = 10'($urandom_range(300) - 150);
            c.tilt_deg = 10'($urandom_range(300) - 150);
        end
        else
        begin
            c.yaw_deg = 10'($urandom);
            c.tilt_deg = 10'($urandom);
        end
        c.speed = 10'($urandom);
        c.home_time = 16'($urandom);
        c.torque_on = 1'($urandom);
        return c;
    endfunction

    task automatic send_cmd(head_cmd_t c);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= c.cmd;
        s_axis_tdata <= {1'b0, c.torque_on, c.home_time, c.speed, c.tilt_deg, c.yaw_deg};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        frames.note_command(c);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (frames.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [9:0] value);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        frames.write_reg(idx, value);
    endtask

    task automatic load_regs(cfg_t r);
        write_reg(REG_YAW_ID, {2'b0, r.yaw_id});
        write_reg(REG_PITCH_ID, {2'b0, r.tilt_id});
        write_reg(REG_YAW_REST, r.yaw_center);
        write_reg(REG_YAW_MIN, r.yaw_min);
        write_reg(REG_YAW_MAX, r.yaw_max);
        write_reg(REG_PITCH_REST, r.tilt_center);
        write_reg(REG_PITCH_MIN, r.tilt_min);
        write_reg(REG_PITCH_MAX, r.tilt_max);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(cfg_t r, int idle, int stall, int n, bit with_hold);
        load_regs(r);
        idle_pct <= idle;
        stall_pct <= stall;
        if (with_hold)
        begin
            fork
                begin
                    hold <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    hold <= 1'b0;
                end
            join_none
        end
        for (int i = 0; i < n; i++)
        begin
            send_cmd(random_cmd());
            if (i == n / 2 || $urandom_range(99) < 2)
            begin
                while (frames.pending() != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    @(posedge clk);
                end
            end
        end
        wait_drained();
    endtask

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults, no idling: extremes of the fields, every command and the clamps.
        send_cmd(make_cmd(CMD_MOVE, 0, 0, 0, 0, 1'b0));
        send_cmd(make_cmd(CMD_MOVE, -512, -512, 1000, 0, 1'b0));
        send_cmd(make_cmd(CMD_MOVE, 511, 511, 1001, 0, 1'b0));
        send_cmd(make_cmd(CMD_MOVE, -1, 1, 1023, 0, 1'b0));
        send_cmd(make_cmd(CMD_MOVE, -7, 7, 500, 0, 1'b0));
        send_cmd(make_cmd(CMD_MOVE, -125, 81, 1, 0, 1'b0));
        send_cmd(make_cmd(CMD_MOVE, 125, -6, 999, 0, 1'b0));
        send_cmd(make_cmd(CMD_TORQUE, 33, -33, 0, 0, 1'b1));
        send_cmd(make_cmd(CMD_TORQUE, 0, 0, 0, 0, 1'b0));
        send_cmd(make_cmd(CMD_HOME, 100, 100, 0, 0, 1'b0));
        send_cmd(make_cmd(CMD_HOME, 0, 0, 0, 65535, 1'b0));
        send_cmd(make_cmd(CMD_MOVE, 300, -300, 700, 0, 1'b0));
        send_cmd(make_cmd(CMD_UNUSED, 511, 511, 1023, 65535, 1'b1));
        send_cmd(make_cmd(CMD_HOME, 0, 0, 0, 16'h1234, 1'b0));
        send_cmd(make_cmd(CMD_UNUSED, -512, -512, 0, 0, 1'b0));
        send_cmd(make_cmd(CMD_TORQUE, 0, 0, 1023, 65535, 1'b1));
        send_cmd(make_cmd(CMD_MOVE, 6, -63, 341, 0, 1'b0));
        wait_drained();

        run_phase('{8'd0, 8'd253, 10'd0, 10'd0, 10'd1000, 10'd1000, 10'd0, 10'd1000},
                  0, 0, 66, 1'b0);
        run_phase('{8'd253, 8'd0, 10'd1000, 10'd1000, 10'd1000, 10'd0, 10'd0, 10'd0},
                  48, 0, 66, 1'b0);
        run_phase('{8'($urandom_range(253)), 8'($urandom_range(253)),
                    10'($urandom_range(1000)), 10'd900, 10'd100,
                    10'($urandom_range(1000)), 10'd700, 10'd300},
                  0, 48, 66, 1'b0);
        run_phase('{8'($urandom_range(253)), 8'($urandom_range(253)),
                    10'($urandom_range(1000)), 10'($urandom_range(1000)),
                    10'($urandom_range(1000)), 10'($urandom_range(1000)),
                    10'($urandom_range(1000)), 10'($urandom_range(1000))},
                  27, 27, 66, 1'b0);
        run_phase('{RST_YAW_ID, RST_PITCH_ID, RST_YAW_REST, RST_YAW_MIN, RST_YAW_MAX,
                    RST_PITCH_REST, RST_PITCH_MIN, RST_PITCH_MAX},
                  0, 0, 66, 1'b1);

        if (frames.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
